[sv/assert_macros.svh]
// Assertion macros shared by the RLS estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on rising clk outside reset
`define AST_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AST_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/rls_pkg.sv]
// Shared types, constants and saturation helpers for the RLS estimator.
`timescale 1ns / 1ps
`default_nettype none
package rls_pkg;

  localparam int NP    = 8;
  localparam int PW    = 48;
  localparam int DW    = 32;
  localparam int ACC_W = 100;
  localparam int FRAC  = 24;
  localparam int NUM_W = PW + FRAC;

  typedef logic signed [PW-1:0]    pval_t;
  typedef logic signed [DW-1:0]    dval_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t  ONE_Q    = acc_t'(1) <<< FRAC;
  localparam pval_t DIAG_RST = pval_t'(64'd1000 << FRAC);

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_PX   = 3'd1;
  localparam logic [2:0] OP_R    = 3'd2;
  localparam logic [2:0] OP_DEN  = 3'd3;
  localparam logic [2:0] OP_UPD  = 3'd4;
  localparam logic [2:0] OP_E    = 3'd5;
  localparam logic [2:0] OP_G    = 3'd6;
  localparam logic [2:0] OP_W    = 3'd7;

  localparam logic [1:0] TD_R   = 2'd0;
  localparam logic [1:0] TD_DEN = 2'd1;
  localparam logic [1:0] TD_E   = 2'd2;

  localparam logic [1:0] STEP_COMMIT = 2'd3;
  localparam logic [2:0] J_LAST      = 3'(NP - 1);

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] step;
    logic [2:0] j;
    logic       restart;
    logic       div_start;
    logic       k_load;
  } lane_ctl_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] dest;
    logic [2:0] j;
  } tree_tag_t;

  function automatic pval_t sat48(input acc_t v);
    if ((&v[ACC_W-1:PW-1]) || !(|v[ACC_W-1:PW-1])) return v[PW-1:0];
    return v[ACC_W-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
  endfunction

  function automatic dval_t sat32(input acc_t v);
    if ((&v[ACC_W-1:DW-1]) || !(|v[ACC_W-1:DW-1])) return v[DW-1:0];
    return v[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

endpackage
`default_nettype wire

[sv/rls_div.sv]
// Restoring divider, one quotient bit per cycle, saturated Q24.24 gain.
`timescale 1ns / 1ps
`default_nettype none
module rls_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [rls_pkg::NUM_W-1:0] num,
  input  wire rls_pkg::pval_t                 den,
  output rls_pkg::pval_t                      quo
);

  logic                          neg;
  logic [rls_pkg::NUM_W-1:0]     nm;
  logic [rls_pkg::PW-1:0]        dm;
  logic [rls_pkg::PW-1:0]        rem;
  logic [rls_pkg::NUM_W-1:0]     q;
  logic [6:0]                    cnt;
  logic [rls_pkg::PW:0]          rs;
  logic                          ge;
  logic signed [rls_pkg::NUM_W:0] qs;

  assign rs = {rem, nm[rls_pkg::NUM_W-1]};
  assign ge = rs >= {1'b0, dm};
  assign qs = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  assign quo = rls_pkg::sat48(rls_pkg::ACC_W'(qs));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= 7'(rls_pkg::NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[rls_pkg::NUM_W-1] ^ den[rls_pkg::PW-1];
      nm  <= num[rls_pkg::NUM_W-1] ? 72'(-num) : 72'(num);
      dm  <= den[rls_pkg::PW-1] ? 48'(-den) : 48'(den);
      rem <= '0;
      q   <= '0;
    end else if (cnt != '0) begin
      nm  <= {nm[rls_pkg::NUM_W-2:0], 1'b0};
      rem <= ge ? rls_pkg::PW'(rs - {1'b0, dm}) : rs[rls_pkg::PW-1:0];
      q   <= {q[rls_pkg::NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[sv/rls_lane.sv]
// One lane: covariance row, weight and gain terms with a digit-step multiplier.
`timescale 1ns / 1ps
`default_nettype none
module rls_lane (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [2:0]         id,
  input  wire rls_pkg::lane_ctl_t ctl,
  input  wire rls_pkg::dval_t     x [rls_pkg::NP],
  input  wire rls_pkg::pval_t     r [rls_pkg::NP],
  input  wire rls_pkg::pval_t     den,
  input  wire rls_pkg::pval_t     e,
  input  wire rls_pkg::pval_t     diag,
  output rls_pkg::acc_t           prod,
  output rls_pkg::dval_t          w
);

  rls_pkg::pval_t prow [rls_pkg::NP];
  rls_pkg::pval_t px, k, g, a, b, quo;
  rls_pkg::acc_t  acc, ppx, sum, acc_sum;
  logic signed [16:0] dig;
  logic signed [64:0] pp;
  logic commit;

  rls_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   ({px, {rls_pkg::FRAC{1'b0}}}),
    .den   (den),
    .quo   (quo)
  );

  always_comb begin
    case (ctl.op) inside
      rls_pkg::OP_PX, rls_pkg::OP_G: begin
        a = prow[ctl.j];
        b = 48'(x[ctl.j]);
      end
      rls_pkg::OP_R: begin
        a = prow[ctl.j];
        b = 48'(x[id]);
      end
      rls_pkg::OP_DEN: begin
        a = px;
        b = 48'(x[id]);
      end
      rls_pkg::OP_UPD: begin
        a = k;
        b = r[ctl.j];
      end
      rls_pkg::OP_E: begin
        a = 48'(w);
        b = 48'(x[id]);
      end
      rls_pkg::OP_W: begin
        a = g;
        b = e;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  always_comb begin
    case (ctl.step)
      2'd0:    dig = $signed({1'b0, b[15:0]});
      2'd1:    dig = $signed({1'b0, b[31:16]});
      default: dig = $signed({b[47], b[47:32]});
    endcase
  end

  assign pp = a * dig;

  always_comb begin
    case (ctl.step)
      2'd0:    ppx = rls_pkg::ACC_W'(pp);
      2'd1:    ppx = rls_pkg::ACC_W'(pp) <<< 16;
      default: ppx = rls_pkg::ACC_W'(pp) <<< 32;
    endcase
  end

  assign sum     = (ctl.step == 2'd0) ? ppx : prod + ppx;
  assign acc_sum = (ctl.j == 3'd0) ? prod : acc + prod;
  assign commit  = ctl.step == rls_pkg::STEP_COMMIT;

  // covariance row and weight carry architectural reset values
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      for (int m = 0; m < rls_pkg::NP; m++) begin
        prow[m] <= (3'(m) == id) ? (rst ? rls_pkg::DIAG_RST : diag) : '0;
      end
      w <= '0;
    end else if (commit) begin
      if (ctl.op == rls_pkg::OP_UPD) begin
        prow[ctl.j] <= rls_pkg::sat48(rls_pkg::ACC_W'(prow[ctl.j]) - (prod >>> rls_pkg::FRAC));
      end
      if (ctl.op == rls_pkg::OP_W) begin
        w <= rls_pkg::sat32(rls_pkg::ACC_W'(w) + (prod >>> rls_pkg::FRAC));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op != rls_pkg::OP_NONE && !commit) begin
      prod <= sum;
    end
    if (commit && (ctl.op == rls_pkg::OP_PX || ctl.op == rls_pkg::OP_G)) begin
      acc <= acc_sum;
      if (ctl.j == rls_pkg::J_LAST) begin
        if (ctl.op == rls_pkg::OP_PX) px <= rls_pkg::sat48(acc_sum >>> rls_pkg::FRAC);
        else                          g  <= rls_pkg::sat48(acc_sum >>> rls_pkg::FRAC);
      end
    end
    if (ctl.k_load) begin
      k <= quo;
    end
  end

endmodule
`default_nettype wire

[sv/rls_merge.sv]
// Registered adder tree across lanes; produces r, denominator and error.
`timescale 1ns / 1ps
`default_nettype none
module rls_merge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rls_pkg::tree_tag_t tag,
  input  wire rls_pkg::acc_t      prod [rls_pkg::NP],
  input  wire rls_pkg::dval_t     y,
  output rls_pkg::pval_t          r [rls_pkg::NP],
  output rls_pkg::pval_t          den,
  output rls_pkg::pval_t          e
);

  rls_pkg::acc_t l1 [4];
  rls_pkg::acc_t l2 [2];
  rls_pkg::acc_t l3, sh;
  rls_pkg::tree_tag_t t1, t2, t3;

  assign sh = l3 >>> rls_pkg::FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
    end else begin
      t1 <= tag;
      t2 <= t1;
      t3 <= t2;
    end
  end

  always_ff @(posedge clk) begin
    for (int m = 0; m < 4; m++) l1[m] <= prod[2*m] + prod[2*m+1];
    for (int m = 0; m < 2; m++) l2[m] <= l1[2*m] + l1[2*m+1];
    l3 <= l2[0] + l2[1];
    if (t3.vld) begin
      unique case (t3.dest)
        rls_pkg::TD_R:   r[t3.j] <= rls_pkg::sat48(sh);
        rls_pkg::TD_DEN: den     <= rls_pkg::sat48(sh + rls_pkg::ONE_Q);
        rls_pkg::TD_E:   e       <= rls_pkg::sat48(rls_pkg::ACC_W'(y) - sh);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/recursive_least_squares_update.sv]
// Top level of the RLS estimator: sequencer, input/output registers, lanes and merge tree.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata x_0..x_7, target; tuser command
//  m_*     | out | m_tvalid/m_tready  | tdata weight_index, weight; tlast last
//  cfg_*   | in  | cfg_we             | cfg_wdata initial_scale
//
// Update: each matrix pass steps through 8 elements on the lane multiplier
// (three 16-bit digit steps and a commit each), the gain divide uses a
// restoring divider per lane, then 8 output words.
// Zero denominator skips divide and covariance pass.
// Restart emits no word. Reset is synchronous, rst high.
// s_tready is high only when idle; a stalled m_tready holds the word.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module recursive_least_squares_update (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [287:0] s_tdata,   // x_0 [31:0] .. x_7 [255:224], target [287:256]
  input  wire logic [0:0]   s_tuser,   // command [0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,   // weight_index [2:0], weight [34:3], zero [39:35]
  output logic              m_tlast,
  input  wire logic         cfg_we,
  input  wire logic [23:0]  cfg_wdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PX   = 4'd1;
  localparam logic [3:0] S_R    = 4'd2;
  localparam logic [3:0] S_DEN  = 4'd3;
  localparam logic [3:0] S_E    = 4'd4;
  localparam logic [3:0] S_WAIT = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_KLD  = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_G    = 4'd9;
  localparam logic [3:0] S_W    = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [6:0] TREE_WAIT = 7'd4;
  localparam logic [6:0] DIV_WAIT  = 7'(rls_pkg::NUM_W);

  logic [3:0] state, state_next;
  logic [2:0] j, j_next;
  logic [1:0] step, step_next;
  logic [6:0] wcnt, wcnt_next;
  logic [2:0] oidx;
  logic       ovalid;
  logic [23:0] scale;

  rls_pkg::dval_t xr [rls_pkg::NP];
  rls_pkg::dval_t yr;
  rls_pkg::acc_t  prod [rls_pkg::NP];
  rls_pkg::dval_t w [rls_pkg::NP];
  rls_pkg::pval_t r [rls_pkg::NP];
  rls_pkg::pval_t den, e, diag;

  rls_pkg::lane_ctl_t ctl;
  rls_pkg::tree_tag_t tag;

  logic s_acc, looping, single, last_el, den_nz;

  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = state == S_IDLE;
  assign den_nz   = den != '0;
  assign diag     = scale[23] ? {1'b0, {(rls_pkg::PW-1){1'b1}}}
                              : {1'b0, scale[22:0], {rls_pkg::FRAC{1'b0}}};

  assign looping = state == S_PX || state == S_R || state == S_UPD || state == S_G;
  assign single  = state == S_DEN || state == S_E || state == S_W;
  assign last_el = step == rls_pkg::STEP_COMMIT && (single || j == rls_pkg::J_LAST);

  always_comb begin
    ctl.op = rls_pkg::OP_NONE;
    unique case (state)
      S_PX:    ctl.op = rls_pkg::OP_PX;
      S_R:     ctl.op = rls_pkg::OP_R;
      S_DEN:   ctl.op = rls_pkg::OP_DEN;
      S_E:     ctl.op = rls_pkg::OP_E;
      S_UPD:   ctl.op = rls_pkg::OP_UPD;
      S_G:     ctl.op = rls_pkg::OP_G;
      S_W:     ctl.op = rls_pkg::OP_W;
      default: ctl.op = rls_pkg::OP_NONE;
    endcase
    ctl.step      = step;
    ctl.j         = j;
    ctl.restart   = s_acc && s_tuser[0];
    ctl.div_start = state == S_WAIT && wcnt == '0 && den_nz;
    ctl.k_load    = state == S_KLD;
  end

  always_comb begin
    tag.vld  = step == rls_pkg::STEP_COMMIT &&
               (state == S_R || state == S_DEN || state == S_E);
    tag.dest = (state == S_R) ? rls_pkg::TD_R :
               (state == S_DEN) ? rls_pkg::TD_DEN : rls_pkg::TD_E;
    tag.j    = j;
  end

  always_comb begin
    state_next = state;
    j_next     = j;
    step_next  = step;
    wcnt_next  = wcnt;
    if (looping || single) begin
      step_next = step + 2'd1;
      if (step == rls_pkg::STEP_COMMIT) j_next = last_el ? 3'd0 : j + 3'd1;
    end
    unique case (state)
      S_IDLE: if (s_acc && !s_tuser[0]) state_next = S_PX;
      S_PX:   if (last_el) state_next = S_R;
      S_R:    if (last_el) state_next = S_DEN;
      S_DEN:  if (last_el) state_next = S_E;
      S_E: begin
        if (last_el) begin
          state_next = S_WAIT;
          wcnt_next  = TREE_WAIT;
        end
      end
      S_WAIT: begin
        if (wcnt == '0) begin
          state_next = den_nz ? S_DIV : S_G;
          wcnt_next  = DIV_WAIT;
        end else begin
          wcnt_next = wcnt - 7'd1;
        end
      end
      S_DIV: begin
        if (wcnt == '0) state_next = S_KLD;
        else            wcnt_next = wcnt - 7'd1;
      end
      S_KLD:  state_next = S_UPD;
      S_UPD:  if (last_el) state_next = S_G;
      S_G:    if (last_el) state_next = S_W;
      S_W:    if (last_el) state_next = S_OUT;
      S_OUT:  if (m_tready && oidx == rls_pkg::J_LAST) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      j      <= '0;
      step   <= '0;
      wcnt   <= '0;
      ovalid <= 1'b0;
      oidx   <= '0;
      scale  <= 24'd1000;
    end else begin
      state <= state_next;
      j     <= j_next;
      step  <= step_next;
      wcnt  <= wcnt_next;
      if (cfg_we) scale <= cfg_wdata;
      if (state == S_W && last_el) begin
        ovalid <= 1'b1;
        oidx   <= '0;
      end else if (ovalid && m_tready) begin
        if (oidx == rls_pkg::J_LAST) ovalid <= 1'b0;
        oidx <= oidx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && !s_tuser[0]) begin
      for (int m = 0; m < rls_pkg::NP; m++) xr[m] <= s_tdata[32*m +: 32];
      yr <= s_tdata[287:256];
    end
  end

  // lane weights hold steady while words are out
  assign m_tvalid = ovalid;
  assign m_tdata  = {5'b0, w[oidx], oidx};
  assign m_tlast  = oidx == rls_pkg::J_LAST;

  for (genvar gi = 0; gi < rls_pkg::NP; gi++) begin : g_lane
    rls_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .id   (3'(gi)),
      .ctl  (ctl),
      .x    (xr),
      .r    (r),
      .den  (den),
      .e    (e),
      .diag (diag),
      .prod (prod[gi]),
      .w    (w[gi])
    );
  end

  rls_merge u_merge (
    .clk  (clk),
    .rst  (rst),
    .tag  (tag),
    .prod (prod),
    .y    (yr),
    .r    (r),
    .den  (den),
    .e    (e)
  );

  `AST_IMP(a_idle_no_word, s_tready, !m_tvalid, "input ready while a word is pending")
  `AST_NXT(a_update_busy, s_tvalid && s_tready && !s_tuser[0], !s_tready, "update not started")
  `AST_NXT(a_last_idle, m_tvalid && m_tready && m_tlast, s_tready, "no return to idle")

endmodule
`default_nettype wire
